### rtl/dsld_pkg.sv
// Shared types and constants for the lax DER signature decoder.
`timescale 1ns / 1ps
`default_nettype none
package dsld_pkg;
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] LONG_FORM    = 8'h80;
  localparam int STRICT_MAX  = 72;
  localparam int STRICT_MIN  = 8;
  localparam int VALUE_BYTES = 32;
  localparam int LIMBS       = 4;

  localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
  localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
  localparam logic [3:0] PH_SEQ_SKIP = 4'd2;
  localparam logic [3:0] PH_R_TAG    = 4'd3;
  localparam logic [3:0] PH_R_LEN    = 4'd4;
  localparam logic [3:0] PH_R_LONG   = 4'd5;
  localparam logic [3:0] PH_R_VAL    = 4'd6;
  localparam logic [3:0] PH_S_TAG    = 4'd7;
  localparam logic [3:0] PH_S_LEN    = 4'd8;
  localparam logic [3:0] PH_S_LONG   = 4'd9;
  localparam logic [3:0] PH_S_VAL    = 4'd10;
  localparam logic [3:0] PH_DONE     = 4'd11;

  localparam logic [255:0] GROUP_ORDER =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;

  // Summary of one closed signature handed from the parser to the emitter.
  typedef struct packed {
    logic [255:0] r;
    logic [255:0] s;
    logic         rejected;
    logic         zeroed;
  } sig_result_t;
endpackage
`default_nettype wire

### rtl/der_signature_lax_decoder.sv
// Top level of the lax DER ECDSA signature decoder.
//
// Input channel (in_valid/in_ready) takes one signature byte per word with
// last_byte, no_bytes and strict (strict is sampled on the first byte).
// Bytes are taken one per cycle while in_ready is high; the parser tracks
// the DER structure as they arrive.
// When a signature closes, its summary passes a close-check register, then
// a result register, then a two-entry queue in the emitter. The output
// channel (out_valid/out_ready) sends eight words: r limbs 0-3 then s limbs
// 0-3, least significant limb first, with status and value_zeroed.
// Each signature needs eight output words, which is the limit when
// signatures are short. A stalled receiver fills the queue, then the
// result register, then the close-check register on the next close, and
// then holds in_ready low.
// Reset (rst, synchronous) clears the parse state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module der_signature_lax_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sig_byte,
  input  wire logic        last_byte,
  input  wire logic        no_bytes,
  input  wire logic        strict,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      value_word,
  output logic [2:0]       word_index,
  output logic             status,
  output logic             value_zeroed,
  output logic             last_word
);
  logic res_valid, res_ready;
  dsld_pkg::sig_result_t res;

  dsld_parser #(.COUNT_BITS(COUNT_BITS)) u_parser (
    .clk, .rst, .in_valid, .in_ready, .sig_byte, .last_byte, .no_bytes, .strict,
    .res_valid, .res_ready, .res
  );

  dsld_emitter u_emitter (
    .clk, .rst, .res_valid, .res_ready, .res,
    .out_valid, .out_ready, .value_word, .word_index, .status, .value_zeroed, .last_word
  );
endmodule
`default_nettype wire

### rtl/dsld_parser.sv
// Front end: byte-serial lax/strict DER parse, emits one summary per signature.
`timescale 1ns / 1ps
`default_nettype none
module dsld_parser #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        sig_byte,
  input  wire logic              last_byte,
  input  wire logic              no_bytes,
  input  wire logic              strict,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output dsld_pkg::sig_result_t  res
);
  logic [3:0]            phase, phase_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [63:0]           field_rem, field_rem_next;
  logic [6:0]            len_left, len_left_next;
  logic [255:0]          r_val, r_val_next, s_val, s_val_next;
  logic [5:0]            r_sig, r_sig_next, s_sig, s_sig_next;
  logic                  strict_act, strict_act_next;
  logic [7:0]            sl0, sl1, sl2, sl3;
  logic [7:0]            sl0_next, sl1_next, sl2_next, sl3_next;
  logic                  failed, failed_next;
  // Close-time checks are split into a second stage to keep paths short.
  logic                  cl_valid;
  logic                  cl_pre_rej, cl_strict;
  logic [COUNT_BITS-1:0] cl_n;
  logic [7:0]            cl_l0, cl_lr, cl_ls;
  logic [255:0]          cl_r, cl_s;
  logic                  cl_ovf;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic accept, close, cl_adv, res_take;
  assign res_take = res_valid && res_ready;
  assign cl_adv   = cl_valid && (!res_valid || res_ready);
  assign in_ready = !cl_valid || cl_adv;
  assign accept   = in_valid && in_ready;
  assign close    = accept && (last_byte || no_bytes);

  logic [63:0] p;
  logic [63:0] lr64;
  logic        act;
  logic        is_s;
  logic [63:0] fr_shift;

  always_comb begin
    phase_next = phase; byte_count_next = byte_count; field_rem_next = field_rem;
    len_left_next = len_left; r_val_next = r_val; s_val_next = s_val;
    r_sig_next = r_sig; s_sig_next = s_sig; strict_act_next = strict_act;
    sl0_next = sl0; sl1_next = sl1; sl2_next = sl2; sl3_next = sl3;
    failed_next = failed;
    p = 64'(byte_count);
    lr64 = {56'd0, sl1};
    act = strict_act;
    is_s = (phase >= dsld_pkg::PH_S_TAG);
    fr_shift = {field_rem[55:0], sig_byte};
    if (accept && !no_bytes) begin
      if (byte_count == '0) begin
        act = strict;
        strict_act_next = strict;
      end
      if (!failed) begin
        case (phase)
          dsld_pkg::PH_SEQ_TAG: begin
            if (sig_byte != dsld_pkg::TAG_SEQUENCE) failed_next = 1'b1;
            else phase_next = dsld_pkg::PH_SEQ_LEN;
          end
          dsld_pkg::PH_SEQ_LEN: begin
            if (sig_byte[7] && sig_byte[6:0] != 7'd0) begin
              len_left_next = sig_byte[6:0];
              phase_next = dsld_pkg::PH_SEQ_SKIP;
            end else phase_next = dsld_pkg::PH_R_TAG;
          end
          dsld_pkg::PH_SEQ_SKIP: begin
            len_left_next = len_left - 7'd1;
            if (len_left == 7'd1) phase_next = dsld_pkg::PH_R_TAG;
          end
          dsld_pkg::PH_R_TAG, dsld_pkg::PH_S_TAG: begin
            if (sig_byte != dsld_pkg::TAG_INTEGER) failed_next = 1'b1;
            else phase_next = phase + 4'd1;
          end
          dsld_pkg::PH_R_LEN, dsld_pkg::PH_S_LEN: begin
            if (sig_byte[7] && sig_byte[6:0] != 7'd0) begin
              len_left_next = sig_byte[6:0];
              field_rem_next = '0;
              phase_next = phase + 4'd1;
            end else if (sig_byte[7] || sig_byte == 8'd0) begin
              phase_next = is_s ? dsld_pkg::PH_DONE : dsld_pkg::PH_S_TAG;
            end else begin
              field_rem_next = {56'd0, sig_byte};
              phase_next = is_s ? dsld_pkg::PH_S_VAL : dsld_pkg::PH_R_VAL;
            end
          end
          dsld_pkg::PH_R_LONG, dsld_pkg::PH_S_LONG: begin
            if (field_rem == '0 && sig_byte != 8'd0 && len_left >= 7'd8) begin
              failed_next = 1'b1;
            end else begin
              field_rem_next = fr_shift;
              len_left_next = len_left - 7'd1;
              if (len_left == 7'd1) begin
                if (fr_shift == '0)
                  phase_next = is_s ? dsld_pkg::PH_DONE : dsld_pkg::PH_S_TAG;
                else
                  phase_next = is_s ? dsld_pkg::PH_S_VAL : dsld_pkg::PH_R_VAL;
              end
            end
          end
          dsld_pkg::PH_R_VAL: begin
            if (!(r_sig == 6'd0 && sig_byte == 8'd0)) begin
              if (r_sig < 6'(dsld_pkg::VALUE_BYTES)) r_val_next = {r_val[247:0], sig_byte};
              if (r_sig < 6'(dsld_pkg::VALUE_BYTES + 1)) r_sig_next = r_sig + 6'd1;
            end
            field_rem_next = field_rem - 64'd1;
            if (field_rem == 64'd1) phase_next = dsld_pkg::PH_S_TAG;
          end
          dsld_pkg::PH_S_VAL: begin
            if (!(s_sig == 6'd0 && sig_byte == 8'd0)) begin
              if (s_sig < 6'(dsld_pkg::VALUE_BYTES)) s_val_next = {s_val[247:0], sig_byte};
              if (s_sig < 6'(dsld_pkg::VALUE_BYTES + 1)) s_sig_next = s_sig + 6'd1;
            end
            field_rem_next = field_rem - 64'd1;
            if (field_rem == 64'd1) phase_next = dsld_pkg::PH_DONE;
          end
          default: ;
        endcase
        // Strict checks see the byte position before this byte counts.
        if (act && !failed_next) begin
          if (p == 64'd1) sl0_next = sig_byte;
          if (p == 64'd2 && sig_byte != dsld_pkg::TAG_INTEGER) failed_next = 1'b1;
          if (p == 64'd3) begin
            sl1_next = sig_byte;
            if (sig_byte == 8'd0) failed_next = 1'b1;
          end
          if (p >= 64'd4) begin
            if (p == 64'd4) begin
              if (sig_byte[7]) failed_next = 1'b1;
              sl3_next = sig_byte;
            end
            if (p == 64'd5 && lr64 > 64'd1 && sl3 == 8'd0 && !sig_byte[7])
              failed_next = 1'b1;
            if (p == 64'd4 + lr64 && sig_byte != dsld_pkg::TAG_INTEGER) failed_next = 1'b1;
            if (p == 64'd5 + lr64) begin
              sl2_next = sig_byte;
              if (sig_byte == 8'd0) failed_next = 1'b1;
            end
            if (p == 64'd6 + lr64) begin
              if (sig_byte[7]) failed_next = 1'b1;
              sl3_next = sig_byte;
            end
            if (p == 64'd7 + lr64 && sl2 > 8'd1 && sl3 == 8'd0 && !sig_byte[7])
              failed_next = 1'b1;
          end
        end
      end
      if (byte_count != COUNT_MAX) byte_count_next = byte_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || close) begin
      phase <= dsld_pkg::PH_SEQ_TAG; byte_count <= '0; field_rem <= '0; len_left <= '0;
      r_val <= '0; s_val <= '0; r_sig <= '0; s_sig <= '0; strict_act <= 1'b0;
      sl0 <= '0; sl1 <= '0; sl2 <= '0; sl3 <= '0; failed <= 1'b0;
    end else begin
      phase <= phase_next; byte_count <= byte_count_next; field_rem <= field_rem_next;
      len_left <= len_left_next; r_val <= r_val_next; s_val <= s_val_next;
      r_sig <= r_sig_next; s_sig <= s_sig_next; strict_act <= strict_act_next;
      sl0 <= sl0_next; sl1 <= sl1_next; sl2 <= sl2_next; sl3 <= sl3_next;
      failed <= failed_next;
    end
  end

  // Latch the closed signature.
  always_ff @(posedge clk) begin
    if (rst) cl_valid <= 1'b0;
    else if (close) cl_valid <= 1'b1;
    else if (cl_adv) cl_valid <= 1'b0;
    if (close) begin
      cl_pre_rej <= failed_next || byte_count_next == '0 || phase_next != dsld_pkg::PH_DONE;
      cl_strict  <= strict_act_next;
      cl_n  <= byte_count_next;
      cl_l0 <= sl0_next; cl_lr <= sl1_next; cl_ls <= sl2_next;
      cl_r  <= r_val_next; cl_s <= s_val_next;
      cl_ovf <= r_sig_next > 6'(dsld_pkg::VALUE_BYTES) ||
                s_sig_next > 6'(dsld_pkg::VALUE_BYTES);
    end
  end

  logic [COUNT_BITS+1:0] n_w;
  logic                  strict_ok, rej, zer;
  always_comb begin
    n_w = (COUNT_BITS+2)'(cl_n);
    strict_ok = !(n_w < (COUNT_BITS+2)'(dsld_pkg::STRICT_MIN) ||
                  n_w > (COUNT_BITS+2)'(dsld_pkg::STRICT_MAX)) &&
                ((COUNT_BITS+2)'(cl_l0) + (COUNT_BITS+2)'(2) == n_w) &&
                ((COUNT_BITS+2)'(cl_lr) + (COUNT_BITS+2)'(5) < n_w) &&
                ((COUNT_BITS+2)'(cl_lr) + (COUNT_BITS+2)'(cl_ls) +
                 (COUNT_BITS+2)'(6) == n_w);
    rej = cl_pre_rej || (cl_strict && !strict_ok);
    zer = !rej && (cl_ovf || cl_r == '0 || cl_s == '0 ||
                   cl_r >= dsld_pkg::GROUP_ORDER || cl_s >= dsld_pkg::GROUP_ORDER);
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cl_adv) res_valid <= 1'b1;
    else if (res_take) res_valid <= 1'b0;
    if (cl_adv) begin
      res.rejected <= rej;
      res.zeroed   <= zer;
      res.r <= (rej || zer) ? '0 : cl_r;
      res.s <= (rej || zer) ? '0 : cl_s;
    end
  end
endmodule
`default_nettype wire

### rtl/dsld_emitter.sv
// Back end: a two-entry summary queue and the eight-word output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dsld_emitter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire dsld_pkg::sig_result_t res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            value_word,
  output logic [2:0]             word_index,
  output logic                   status,
  output logic                   value_zeroed,
  output logic                   last_word
);
  dsld_pkg::sig_result_t q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic [2:0] idx;
  logic       push, pop, take;
  dsld_pkg::sig_result_t h;

  assign res_ready = cnt != 2'd2;
  assign push = res_valid && res_ready;
  assign take = out_valid && out_ready;
  assign pop  = take && idx == 3'd7;
  assign out_valid = cnt != 2'd0;
  assign h = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= res;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0; idx <= 3'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (take) idx <= idx + 3'd1;
    end
  end

  always_comb begin
    case (idx[1:0])
      2'd0: value_word = idx[2] ? h.s[63:0]    : h.r[63:0];
      2'd1: value_word = idx[2] ? h.s[127:64]  : h.r[127:64];
      2'd2: value_word = idx[2] ? h.s[191:128] : h.r[191:128];
      default: value_word = idx[2] ? h.s[255:192] : h.r[255:192];
    endcase
  end
  assign word_index   = idx;
  assign status       = h.rejected;
  assign value_zeroed = h.zeroed;
  assign last_word    = idx == 3'd7;
endmodule
`default_nettype wire

### rtl/dsld_checker.sv
// Port-level checks for the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dsld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] value_word,
  input wire logic [2:0]  word_index,
  input wire logic        status,
  input wire logic        value_zeroed,
  input wire logic        last_word
);
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word out of step with word_index");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> (word_index == $past(word_index) + 3'd1))
    else $error("word index did not advance");
  a_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (value_word == 64'd0 && !value_zeroed))
    else $error("rejected signature shows data");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_zeroed |-> value_word == 64'd0)
    else $error("zeroed signature shows data");
endmodule

bind der_signature_lax_decoder dsld_checker u_dsld_checker (
  .clk, .rst, .out_valid, .out_ready, .value_word, .word_index, .status,
  .value_zeroed, .last_word
);
`default_nettype wire
